FILE: hw/rtl/voxel_strain_stress_von_mises_assert.svh
// Assertion macros used by the checker file.
`ifndef VOXEL_STRAIN_STRESS_VON_MISES_ASSERT_SVH
`define VOXEL_STRAIN_STRESS_VON_MISES_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define VSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequence is checked in the cycle after the antecedent.
`define VSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/vssvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vssvm_pkg
// Shared types and constants for the voxel strain/stress block.
// ----------------------------------------------------------------------------
package vssvm_pkg;
  localparam int unsigned NUM_CFG  = 3;
  localparam int unsigned NUM_COMP = 6;
  localparam logic [1:0] CFG_RX = 2'd0;
  localparam logic [1:0] CFG_RY = 2'd1;
  localparam logic [1:0] CFG_RZ = 2'd2;
endpackage

FILE: hw/rtl/vssvm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vssvm_front
// Accumulate eight corner words into nine gradient sums; hand a voxel off.
// ----------------------------------------------------------------------------
module vssvm_front #(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [WORD_BITS-1:0] dx,
  input  logic signed [WORD_BITS-1:0] dy,
  input  logic signed [WORD_BITS-1:0] dz,
  input  logic        [WORD_BITS-1:0] lam,
  input  logic        [WORD_BITS-1:0] mu,
  output logic                        v_valid,
  input  logic                        v_ready,
  output logic signed [WORD_BITS+7:0] v_sum [9],
  output logic        [WORD_BITS-1:0] v_lam,
  output logic        [WORD_BITS-1:0] v_mu
);
  import vssvm_pkg::*;
  localparam int SW = WORD_BITS + 8;

  logic [2:0] cnt_r;
  logic signed [SW-1:0] acc_r [9];
  logic signed [SW-1:0] acc_nxt [9];
  logic full_r;
  logic take;
  logic signed [SW-1:0] dext [3];

  assign in_ready = !full_r || v_ready;
  assign take     = in_valid && in_ready;
  assign v_valid  = full_r;
  assign dext[0]  = SW'(dx);
  assign dext[1]  = SW'(dy);
  assign dext[2]  = SW'(dz);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int d = 0; d < 3; d++) begin
        acc_nxt[c*3+d] = (cnt_r == 3'd0) ? '0 : acc_r[c*3+d];
        if (cnt_r[d]) acc_nxt[c*3+d] = acc_nxt[c*3+d] + dext[c];
        else          acc_nxt[c*3+d] = acc_nxt[c*3+d] - dext[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      full_r <= 1'b0;
    end else begin
      full_r <= (full_r && !v_ready) || (take && cnt_r == 3'd7);
      if (take) cnt_r <= cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 9; i++) acc_r[i] <= acc_nxt[i];
      if (cnt_r == 3'd7) begin
        for (int i = 0; i < 9; i++) v_sum[i] <= acc_nxt[i];
        v_lam <= lam;
        v_mu  <= mu;
      end
    end
  end
endmodule

FILE: hw/rtl/vssvm_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vssvm_sqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module vssvm_sqrt #(
  parameter int RW = 128
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [RW-1:0]   rad,
  output logic            done,
  output logic [RW/2-1:0] root
);
  localparam int HW = RW / 2;
  localparam int CW = $clog2(HW + 1);

  logic [RW-1:0] rem_r;
  logic [RW-1:0] rem_nxt;
  logic [HW-1:0] q_r;
  logic [HW-1:0] q_nxt;
  logic [RW+1:0] part_r;
  logic [RW+1:0] part_nxt;
  logic [RW+1:0] trial;
  logic [CW-1:0] n_r;
  logic busy_r;

  // Classic shift-subtract: bring in two radicand bits per step.
  always_comb begin
    part_nxt = {part_r[RW-1:0], rem_r[RW-1 -: 2]};
    rem_nxt  = {rem_r[RW-3:0], 2'b00};
    trial    = {q_r, 2'b01};
    q_nxt    = {q_r[HW-2:0], 1'b0};
    if (part_nxt >= trial) begin
      part_nxt = part_nxt - trial;
      q_nxt[0] = 1'b1;
    end
  end

  assign root = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      n_r    <= '0;
    end else begin
      done <= !start && busy_r && (n_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        n_r    <= CW'(HW);
      end else if (busy_r) begin
        n_r <= n_r - CW'(1);
        if (n_r == CW'(1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= rad;
      q_r    <= '0;
      part_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      part_r <= part_nxt;
    end
  end
endmodule

FILE: hw/rtl/vssvm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vssvm_back
// Sequenced tensor math on one voxel: gradients, strain, stress, roots, emit.
// ----------------------------------------------------------------------------
module vssvm_back #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic        [WORD_BITS-1:0] rx,
  input  logic        [WORD_BITS-1:0] ry,
  input  logic        [WORD_BITS-1:0] rz,
  input  logic                        v_valid,
  output logic                        v_ready,
  input  logic signed [WORD_BITS+7:0] v_sum [9],
  input  logic        [WORD_BITS-1:0] v_lam,
  input  logic        [WORD_BITS-1:0] v_mu,
  output logic                        o_valid,
  input  logic                        o_ready,
  output logic        [2:0]           o_comp,
  output logic        [WORD_BITS-1:0] o_strain,
  output logic        [WORD_BITS-1:0] o_stress,
  output logic        [WORD_BITS-1:0] o_vms,
  output logic        [WORD_BITS-1:0] o_vme,
  output logic                        o_last
);
  import vssvm_pkg::*;
  localparam int W  = WORD_BITS;
  localparam int SW = W + 8;
  localparam int PW = 2 * W + 12;          // product width, signed
  localparam int AW = 2 * W + 8;           // accumulator width
  localparam int RW = 2 * ((AW + 1) / 2);  // even radicand width
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_GRAD, S_DEV, S_SHR, S_STR, S_ACC, S_ROOT, S_WAIT, S_DIV, S_EMIT
  } state_t;

  state_t st_r;
  logic [3:0] i_r;
  logic signed [SW-1:0] sum_r [9];
  logic signed [W-1:0]  g_r [9];
  logic signed [W-1:0]  e_r [6];
  logic signed [W-1:0]  s_r [6];
  logic [W-1:0] lam_r, mu_r;
  logic signed [AW-1:0] accs_r, acce_r;
  logic [W-1:0] vms_r, vme_r;
  logic [2:0] oc_r;
  logic rs_start_r, re_start_r;
  logic rs_done, re_done;
  logic [RW/2-1:0] rs_root, re_root;
  logic [RW/2-1:0] re_hold_r;

  function automatic logic signed [W-1:0] sat(input logic signed [PW-1:0] v);
    if (v > PW'(SMAX)) return SMAX;
    if (v < PW'(SMIN)) return SMIN;
    return v[W-1:0];
  endfunction

  // gradient: one sum times reciprocal per cycle
  logic [3:0] gi;
  logic [W-1:0] rsel;
  logic signed [PW-1:0] gprod;
  assign gi   = i_r;
  assign rsel = (gi == 4'd0 || gi == 4'd3 || gi == 4'd6) ? rx :
                (gi == 4'd1 || gi == 4'd4 || gi == 4'd7) ? ry : rz;
  assign gprod = (PW'(sum_r[gi[3:0] < 4'd9 ? gi : 4'd0]) * $signed({1'b0, rsel}))
                 >>> (FRAC_BITS + 2);

  // deviatoric: floor((2a-b-c)/3), computed by the reciprocal multiply below
  logic signed [W+2:0] dnum;
  logic signed [W+2:0] dq;
  logic [1:0] di;
  assign di = i_r[1:0];
  always_comb begin
    case (di)
      2'd0:    dnum = 2 * (W+3)'(g_r[0]) - (W+3)'(g_r[4]) - (W+3)'(g_r[8]);
      2'd1:    dnum = 2 * (W+3)'(g_r[4]) - (W+3)'(g_r[0]) - (W+3)'(g_r[8]);
      default: dnum = 2 * (W+3)'(g_r[8]) - (W+3)'(g_r[0]) - (W+3)'(g_r[4]);
    endcase
  end
  // multiply by reciprocal of 3 with correction
  localparam int QW = W + 3;
  localparam logic [QW+1:0] INV3 = ((QW+2)'(1'b1) << (QW + 1)) / 3 + 1;
  logic [QW-1:0] dmag;
  logic [2*QW+1:0] dmul;
  logic [QW-1:0] dqm;
  always_comb begin
    dmag = dnum[QW-1] ? QW'(-dnum - 1) : QW'(dnum);
    dmul = (2*QW+2)'(dmag) * (2*QW+2)'(INV3);
    dqm  = QW'(dmul >> (QW + 1));
    if (QW'(dqm * 3) > dmag) dqm = dqm - 1'b1;
    dq = dnum[QW-1] ? -$signed(dqm) - 1 : $signed(dqm);
  end

  // stress: one product path per cycle
  logic signed [W+2:0] tr;
  logic signed [PW-1:0] p1, p2, sprod;
  assign tr = (W+3)'(e_r[0]) + (W+3)'(e_r[1]) + (W+3)'(e_r[2]);
  assign p1 = PW'($signed({1'b0, lam_r})) * PW'(tr);
  assign p2 = PW'($signed({1'b0, mu_r})) * PW'(e_r[i_r < 4'd6 ? i_r[2:0] : 3'd0]);
  assign sprod = (i_r < 4'd3) ? ((p1 + 2 * p2) >>> FRAC_BITS) : (p2 >>> FRAC_BITS);

  // accumulation: one square/cross term a cycle for each radicand
  logic signed [W-1:0] sa, sb, ea;
  logic signed [2*W-1:0] sprd, eprd;
  logic signed [AW-1:0] sterm, eterm;
  always_comb begin
    sa = s_r[0]; sb = s_r[0]; ea = e_r[0];
    sterm = '0; eterm = '0;
    case (i_r)
      4'd0: begin sa = s_r[0]; sb = s_r[0]; ea = e_r[0]; end
      4'd1: begin sa = s_r[1]; sb = s_r[1]; ea = e_r[1]; end
      4'd2: begin sa = s_r[2]; sb = s_r[2]; ea = e_r[2]; end
      4'd3: begin sa = s_r[0]; sb = s_r[1]; ea = e_r[3]; end
      4'd4: begin sa = s_r[0]; sb = s_r[2]; ea = e_r[4]; end
      4'd5: begin sa = s_r[1]; sb = s_r[2]; ea = e_r[5]; end
      4'd6: begin sa = s_r[3]; sb = s_r[3]; end
      4'd7: begin sa = s_r[4]; sb = s_r[4]; end
      default: begin sa = s_r[5]; sb = s_r[5]; end
    endcase
    sprd = sa * sb;
    eprd = ea * ea;
    if (i_r < 4'd3)      sterm = AW'(sprd);
    else if (i_r < 4'd6) sterm = -AW'(sprd);
    else                 sterm = 3 * AW'(sprd);
    if (i_r < 4'd3)      eterm = 6 * AW'(eprd);
    else if (i_r < 4'd6) eterm = 3 * AW'(eprd);
  end

  vssvm_sqrt #(.RW(RW)) u_rs (
    .clk(clk), .rst_n(rst_n), .start(rs_start_r),
    .rad(accs_r[AW-1] ? RW'(0) : RW'(accs_r)), .done(rs_done), .root(rs_root)
  );
  vssvm_sqrt #(.RW(RW)) u_re (
    .clk(clk), .rst_n(rst_n), .start(re_start_r),
    .rad(RW'(acce_r)), .done(re_done), .root(re_root)
  );

  // vme = floor(root/3) via reciprocal multiply
  localparam int HW = RW / 2;
  localparam logic [HW+1:0] R3 = ((HW+2)'(1'b1) << (HW + 1)) / 3 + 1;
  logic [2*HW+1:0] vmul;
  logic [HW-1:0] vq;
  always_comb begin
    vmul = (2*HW+2)'(re_hold_r) * (2*HW+2)'(R3);
    vq   = HW'(vmul >> (HW + 1));
    if (HW'(vq * 3) > re_hold_r) vq = vq - 1'b1;
  end

  assign v_ready  = (st_r == S_IDLE);
  assign o_valid  = (st_r == S_EMIT);
  assign o_comp   = oc_r;
  assign o_strain = e_r[oc_r];
  assign o_stress = s_r[oc_r];
  assign o_vms    = vms_r;
  assign o_vme    = vme_r;
  assign o_last   = (oc_r == 3'(NUM_COMP - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      i_r        <= '0;
      oc_r       <= '0;
      rs_start_r <= 1'b0;
      re_start_r <= 1'b0;
    end else begin
      // start both roots once the last term is in
      rs_start_r <= (st_r == S_ACC) && (i_r == 4'd8);
      re_start_r <= (st_r == S_ACC) && (i_r == 4'd8);
      unique case (st_r)
        S_IDLE: if (v_valid) begin
          for (int k = 0; k < 9; k++) sum_r[k] <= v_sum[k];
          lam_r <= v_lam;
          mu_r  <= v_mu;
          i_r   <= '0;
          st_r  <= S_GRAD;
        end
        S_GRAD: begin
          g_r[i_r] <= sat(gprod);
          if (i_r == 4'd8) begin i_r <= '0; st_r <= S_DEV; end
          else i_r <= i_r + 4'd1;
        end
        S_DEV: begin
          e_r[i_r[2:0]] <= sat(PW'(dq));
          i_r <= i_r + 4'd1;
          if (i_r == 4'd2) st_r <= S_SHR;
        end
        S_SHR: begin
          e_r[3] <= sat(PW'(g_r[5]) + PW'(g_r[7]));
          e_r[4] <= sat(PW'(g_r[2]) + PW'(g_r[6]));
          e_r[5] <= sat(PW'(g_r[1]) + PW'(g_r[3]));
          i_r  <= '0;
          st_r <= S_STR;
        end
        S_STR: begin
          s_r[i_r[2:0]] <= sat(sprod);
          if (i_r == 4'd5) begin
            i_r <= '0; accs_r <= '0; acce_r <= '0; st_r <= S_ACC;
          end else begin
            i_r <= i_r + 4'd1;
          end
        end
        S_ACC: begin
          accs_r <= accs_r + sterm;
          acce_r <= acce_r + eterm;
          i_r <= i_r + 4'd1;
          if (i_r == 4'd8) st_r <= S_ROOT;
        end
        S_ROOT: if (rs_done && re_done) begin
          vms_r <= (|(rs_root >> W)) ? '1 : W'(rs_root);
          re_hold_r <= re_root;
          st_r <= S_DIV;
        end
        S_DIV: begin
          vme_r <= (|(vq >> W)) ? '1 : W'(vq);
          oc_r  <= '0;
          st_r  <= S_EMIT;
        end
        S_EMIT: if (o_ready) begin
          oc_r <= oc_r + 3'd1;
          if (oc_r == 3'(NUM_COMP - 1)) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hw/rtl/voxel_strain_stress_von_mises.sv
`timescale 1ns / 1ps
// Path: the eighth corner word fills the handoff register; the back end then runs gradient,
//   strain, stress, accumulate, root (one root bit a cycle) and divide states to out_tvalid.
// Throughput: corner words enter one a cycle unless the handoff register holds a voxel that
//   the back end has not taken; it takes a voxel only once the last one's six words are out.
// Reset: synchronous active-low rst_n clears counters, queue and sequencer;
//   reciprocal sizes return to 1.0.
// ----------------------------------------------------------------------------
// voxel_strain_stress_von_mises
// Hexahedral voxel strain, stress and von Mises analysis on corner streams.
// ----------------------------------------------------------------------------
module voxel_strain_stress_von_mises #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // disp_x, disp_y, disp_z, lame_first, lame_shear from bit 0 up
  input  logic [5*WORD_BITS-1:0]     in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // component(3), strain_value, stress_value, von_mises_stress, von_mises_strain,
  // zero fill to bytes
  output logic [((4*WORD_BITS+3+7)/8)*8-1:0] out_tdata,
  output logic                       out_tlast,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [WORD_BITS-1:0]       cfg_data
);
  import vssvm_pkg::*;
  localparam int W = WORD_BITS;
  localparam int OW = ((4*W+3+7)/8)*8;

  logic [W-1:0] rx_r, ry_r, rz_r;
  logic v_valid, v_ready;
  logic signed [W+7:0] v_sum [9];
  logic [W-1:0] v_lam, v_mu;
  logic [2:0] comp;
  logic [W-1:0] strain, stress, vms, vme;

  // Config: accept any cycle, drop indexes beyond the list.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r <= W'(1) << FRAC_BITS;
      ry_r <= W'(1) << FRAC_BITS;
      rz_r <= W'(1) << FRAC_BITS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RX:  rx_r <= cfg_data;
        CFG_RY:  ry_r <= cfg_data;
        CFG_RZ:  rz_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: corner accumulation, one-voxel handoff register as the queue.
  vssvm_front #(.WORD_BITS(W)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .dx(in_tdata[W-1:0]), .dy(in_tdata[2*W-1:W]), .dz(in_tdata[3*W-1:2*W]),
    .lam(in_tdata[4*W-1:3*W]), .mu(in_tdata[5*W-1:4*W]),
    .v_valid(v_valid), .v_ready(v_ready), .v_sum(v_sum), .v_lam(v_lam), .v_mu(v_mu)
  );

  // Back: sequenced tensor math and result emission.
  vssvm_back #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .rx(rx_r), .ry(ry_r), .rz(rz_r),
    .v_valid(v_valid), .v_ready(v_ready), .v_sum(v_sum), .v_lam(v_lam), .v_mu(v_mu),
    .o_valid(out_tvalid), .o_ready(out_tready), .o_comp(comp), .o_strain(strain),
    .o_stress(stress), .o_vms(vms), .o_vme(vme), .o_last(out_tlast)
  );

  assign out_tdata = OW'({vme, vms, stress, strain, comp});
endmodule

FILE: hw/rtl/vssvm_checker.sv
`timescale 1ns / 1ps
`include "voxel_strain_stress_von_mises_assert.svh"
// ----------------------------------------------------------------------------
// vssvm_checker
// Port-level checks of the voxel analysis block.
// ----------------------------------------------------------------------------
module vssvm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic       out_tlast,
  input logic [2:0] comp
);
  `VSS_ASSERT_IMP(a_last_comp, clk, rst_n, out_tvalid, out_tlast == (comp == 3'd5))
  `VSS_ASSERT_IMP(a_comp_range, clk, rst_n, out_tvalid, comp <= 3'd5)
  `VSS_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(comp))
endmodule

bind voxel_strain_stress_von_mises vssvm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tlast(out_tlast), .comp(out_tdata[2:0])
);

FILE: test/tb_voxel_strain_stress_von_mises.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_strain_stress_von_mises
// Streams voxels of eight corner words into the strain/stress block and checks
// every result word against a built-in predictor of the gradient, strain,
// stress and von Mises arithmetic, under several reciprocal-size settings and
// several sender/receiver idling phases.
// ----------------------------------------------------------------------------
module tb_voxel_strain_stress_von_mises;
  import vssvm_pkg::*;

  localparam int W = 32;
  localparam int F = 16;
  localparam int OUT_W = ((4*W+3+7)/8)*8;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam longint UMAX = 64'sd4294967295;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [W-1:0] shear;
    logic [W-1:0] lame1;
    logic [W-1:0] dz;
    logic [W-1:0] dy;
    logic [W-1:0] dx;
  } corner_t;

  typedef struct packed {
    logic [2:0]   comp;
    logic [W-1:0] strain;
    logic [W-1:0] stress;
    logic [W-1:0] vms;
    logic [W-1:0] vme;
    logic         last;
  } result_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [5*W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_RX;
  logic [W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  voxel_strain_stress_von_mises #(.WORD_BITS(W), .FRAC_BITS(F)) uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Predictor state: reciprocal sizes, corner position, nine gradient sums.
  logic [W-1:0] recip [3];
  int unsigned  corner_pos;
  longint       grad_sum [9];

  corner_t corner_queue [$];
  result_t tensor_queue [$];
  int      errors = 0;
  int      send_idle = 0;
  int      recv_stall = 0;
  int      cycle = 0;

  function automatic longint clamp_s(logic signed [127:0] v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return longint'(v);
  endfunction

  // Bit-by-bit integer square root of a nonnegative 128-bit value.
  function automatic logic [63:0] root128(logic signed [127:0] r);
    logic [63:0] res;
    logic [127:0] cand;
    res = 0;
    if (r < 0) return 0;
    for (int b = 63; b >= 0; b--) begin
      cand = {64'd0, res | (64'd1 << b)};
      if (cand * cand <= r) res = res | (64'd1 << b);
    end
    return res;
  endfunction

  function automatic longint floor3(longint n);
    longint q;
    q = n / 3;
    if (n % 3 != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // Accumulate one corner; after the eighth, push the six tensor results.
  function automatic void predict_corner(corner_t c);
    longint disp [3];
    longint g [9];
    longint e [6];
    longint s [6];
    longint lam, mu, tr;
    logic signed [127:0] acc, p, sh;
    logic [63:0] vms, vme;
    result_t r;
    disp[0] = longint'($signed(c.dx));
    disp[1] = longint'($signed(c.dy));
    disp[2] = longint'($signed(c.dz));
    for (int i = 0; i < 3; i++)
      for (int d = 0; d < 3; d++)
        grad_sum[i*3+d] += ((corner_pos >> d) & 1) ? disp[i] : -disp[i];
    if (corner_pos != 7) begin
      corner_pos++;
      return;
    end
    corner_pos = 0;
    for (int i = 0; i < 3; i++)
      for (int d = 0; d < 3; d++) begin
        p = 128'(signed'(grad_sum[i*3+d])) * 128'(signed'({1'b0, recip[d]}));
        g[i*3+d] = clamp_s(p >>> (F + 2));
        grad_sum[i*3+d] = 0;
      end
    e[0] = clamp_s(floor3(2*g[0] - g[4] - g[8]));
    e[1] = clamp_s(floor3(2*g[4] - g[0] - g[8]));
    e[2] = clamp_s(floor3(2*g[8] - g[0] - g[4]));
    e[3] = clamp_s(g[5] + g[7]);
    e[4] = clamp_s(g[2] + g[6]);
    e[5] = clamp_s(g[1] + g[3]);
    lam = longint'({32'd0, c.lame1});
    mu  = longint'({32'd0, c.shear});
    tr  = e[0] + e[1] + e[2];
    for (int i = 0; i < 3; i++) begin
      p = 128'(signed'(lam)) * 128'(signed'(tr)) + 128'(signed'(2*mu)) * 128'(signed'(e[i]));
      s[i] = clamp_s(p >>> F);
    end
    for (int i = 3; i < 6; i++) begin
      p = 128'(signed'(mu)) * 128'(signed'(e[i]));
      s[i] = clamp_s(p >>> F);
    end
    acc = 0;
    for (int i = 0; i < 3; i++) acc += 128'(signed'(s[i])) * 128'(signed'(s[i]));
    acc -= 128'(signed'(s[0])) * 128'(signed'(s[1]));
    acc -= 128'(signed'(s[0])) * 128'(signed'(s[2]));
    acc -= 128'(signed'(s[1])) * 128'(signed'(s[2]));
    sh = 0;
    for (int i = 3; i < 6; i++) sh += 128'(signed'(s[i])) * 128'(signed'(s[i]));
    acc += 3 * sh;
    vms = root128(acc);
    if (vms > UMAX) vms = UMAX;
    acc = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) acc += 128'(signed'(e[i])) * 128'(signed'(e[i]));
    for (int i = 3; i < 6; i++) sh += 128'(signed'(e[i])) * 128'(signed'(e[i]));
    vme = root128(6*acc + 3*sh) / 3;
    if (vme > UMAX) vme = UMAX;
    for (int i = 0; i < 6; i++) begin
      r.comp = 3'(i);
      r.strain = e[i][W-1:0];
      r.stress = s[i][W-1:0];
      r.vms = vms[W-1:0];
      r.vme = vme[W-1:0];
      r.last = (i == 5);
      tensor_queue.push_back(r);
    end
  endfunction

  // Driver: present queued corner words, holding each until accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_corner(corner_t'(in_tdata));
      if (!(in_tvalid && !in_tready)) begin
        if (corner_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_tdata  <= corner_queue.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, compare each result word with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= recv_stall);
      if (out_tvalid && out_tready) begin
        if (tensor_queue.size() == 0) begin
          $error("unexpected result word %h", out_tdata);
          errors++;
        end else begin
          result_t x;
          x = tensor_queue.pop_front();
          if (out_tdata[2:0] !== x.comp) begin
            $error("component exp %0d got %0d", x.comp, out_tdata[2:0]); errors++;
          end
          if (out_tdata[3 +: W] !== x.strain) begin
            $error("strain_value exp %h got %h", x.strain, out_tdata[3 +: W]); errors++;
          end
          if (out_tdata[3+W +: W] !== x.stress) begin
            $error("stress_value exp %h got %h", x.stress, out_tdata[3+W +: W]); errors++;
          end
          if (out_tdata[3+2*W +: W] !== x.vms) begin
            $error("von_mises_stress exp %h got %h", x.vms, out_tdata[3+2*W +: W]); errors++;
          end
          if (out_tdata[3+3*W +: W] !== x.vme) begin
            $error("von_mises_strain exp %h got %h", x.vme, out_tdata[3+3*W +: W]); errors++;
          end
          if (out_tlast !== x.last) begin
            $error("last exp %0d got %0d", x.last, out_tlast); errors++;
          end
        end
      end
    end
  end

  // Cycle limit: stop a hung run.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [W-1:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(1) ? 32'hffffffff : 32'h0;
      3: return $urandom;
      default: return 32'($signed($urandom_range(2*65536*8)) - 65536*8);
    endcase
  endfunction

  function automatic corner_t rand_corner();
    corner_t c;
    c.dx = rand_word();
    c.dy = rand_word();
    c.dz = rand_word();
    c.lame1 = $urandom_range(3) == 0 ? $urandom : $urandom_range(65536*200);
    c.shear = $urandom_range(3) == 0 ? $urandom : $urandom_range(65536*200);
    return c;
  endfunction

  // Wait for every queued corner and expected result, then let the back end drain.
  task automatic drain();
    while (corner_queue.size() > 0 || in_tvalid || tensor_queue.size() > 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < NUM_CFG) recip[idx] = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_voxels(int n);
    repeat (n) for (int k = 0; k < 8; k++) corner_queue.push_back(rand_corner());
  endtask

  initial begin
    corner_t c;
    logic [W-1:0] cfgs [4][3];
    recip[0] = 32'h10000; recip[1] = 32'h10000; recip[2] = 32'h10000;
    corner_pos = 0;
    for (int i = 0; i < 9; i++) grad_sum[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero voxel, extremes with Lame values on non-final corners, then a patterned voxel.
    for (int k = 0; k < 8; k++) begin
      c = '0;
      c.lame1 = 32'hffffffff;
      c.shear = 32'h0;
      corner_queue.push_back(c);
    end
    for (int k = 0; k < 8; k++) begin
      c.dx = (k & 1) ? 32'h7fffffff : 32'h80000000;
      c.dy = (k & 2) ? 32'h80000000 : 32'h7fffffff;
      c.dz = (k & 4) ? 32'h7fffffff : 32'h80000000;
      c.lame1 = (k == 7) ? 32'hffffffff : 32'h1234;
      c.shear = (k == 7) ? 32'hffffffff : 32'h0;
      corner_queue.push_back(c);
    end
    for (int k = 0; k < 8; k++) begin
      c.dx = (k * 32'h13579) ^ 32'h5a5a5a5a;
      c.dy = k[0] ? 32'hffffffff : 32'h1;
      c.dz = 32'h00010000 << k;
      c.lame1 = 32'h00020000;
      c.shear = 32'h00010000;
      corner_queue.push_back(c);
    end
    drain();

    // Settings: extremes, random and fixed values, plus a write to an unused index.
    cfgs[0] = '{32'hffffffff, 32'h0, 32'h10000};
    cfgs[1] = '{32'h0, 32'hffffffff, 32'hffffffff};
    cfgs[2] = '{$urandom, $urandom, $urandom};
    cfgs[3] = '{32'h8000, 32'h20000, 32'h4000};
    for (int ph = 0; ph < 4; ph++) begin
      for (int r = 0; r < 3; r++) write_reg(2'(r), cfgs[ph][r]);
      if (ph == 1) write_reg(2'd3, $urandom);
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 61; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 61; end
        default: begin send_idle = 30; recv_stall = 30; end
      endcase
      push_voxels(7);
      drain();
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/vssvm_pkg.sv
hw/rtl/vssvm_front.sv
hw/rtl/vssvm_sqrt.sv
hw/rtl/vssvm_back.sv
hw/rtl/voxel_strain_stress_von_mises.sv
hw/rtl/vssvm_checker.sv
test/tb_voxel_strain_stress_von_mises.sv
